>>> sv/boi_pkg.sv
// ----------------------------------------------------------------------------
// boi_pkg
// Shared types and default sizes for the box intersection over union block.
// ----------------------------------------------------------------------------
`default_nettype none

package boi_pkg;

  // default coordinate width (Q12.4 edges and spans)
  localparam int COORD_BITS_DEF = 16;
  // default number of fraction bits in the ratio
  localparam int RATIO_BITS_DEF = 16;

  // control that travels alongside each box pair through the pipeline
  typedef struct packed {
    logic valid;  // stage holds a box pair
    logic touch;  // boxes strictly overlap on both axes
    logic keep;   // quotient is meaningful (overlap and nonzero union)
  } ctl_t;

endpackage : boi_pkg

`default_nettype wire

>>> sv/boi_geom.sv
// ----------------------------------------------------------------------------
// boi_geom
// Four-stage front end: far edges, overlap test and intersection size,
// the three areas, and the union area.
// ----------------------------------------------------------------------------
`default_nettype none

module boi_geom #(
  parameter int COORD_BITS = boi_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic                      in_valid,
  input  wire logic [COORD_BITS-1:0]     first_left,
  input  wire logic [COORD_BITS-1:0]     first_top,
  input  wire logic [COORD_BITS-1:0]     first_span_x,
  input  wire logic [COORD_BITS-1:0]     first_span_y,
  input  wire logic [COORD_BITS-1:0]     second_left,
  input  wire logic [COORD_BITS-1:0]     second_top,
  input  wire logic [COORD_BITS-1:0]     second_span_x,
  input  wire logic [COORD_BITS-1:0]     second_span_y,
  output boi_pkg::ctl_t                  ctl_out,
  output logic [2*COORD_BITS-1:0]        area_i_out,
  output logic [2*COORD_BITS:0]          area_u_out
);
  import boi_pkg::*;

  localparam int CB = COORD_BITS;
  // a far edge (signed edge plus unsigned span) needs two bits above the field
  localparam int EW = COORD_BITS + 2;
  localparam int AW = 2 * COORD_BITS;

  // stage 1: near edges sign extended, far edges
  logic                 s1_valid_r;
  logic signed [EW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic signed [EW-1:0] s1_ax2_r, s1_ay2_r, s1_bx2_r, s1_by2_r;
  logic [CB-1:0]        s1_aw_r, s1_ah_r, s1_bw_r, s1_bh_r;

  logic signed [EW-1:0] ax_ext, ay_ext, bx_ext, by_ext;
  logic signed [EW-1:0] ax2_nxt, ay2_nxt, bx2_nxt, by2_nxt;

  assign ax_ext  = $signed({{2{first_left[CB-1]}}, first_left});
  assign ay_ext  = $signed({{2{first_top[CB-1]}}, first_top});
  assign bx_ext  = $signed({{2{second_left[CB-1]}}, second_left});
  assign by_ext  = $signed({{2{second_top[CB-1]}}, second_top});
  assign ax2_nxt = ax_ext + $signed({2'b00, first_span_x});
  assign ay2_nxt = ay_ext + $signed({2'b00, first_span_y});
  assign bx2_nxt = bx_ext + $signed({2'b00, second_span_x});
  assign by2_nxt = by_ext + $signed({2'b00, second_span_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ax_r  <= ax_ext;
      s1_ay_r  <= ay_ext;
      s1_bx_r  <= bx_ext;
      s1_by_r  <= by_ext;
      s1_ax2_r <= ax2_nxt;
      s1_ay2_r <= ay2_nxt;
      s1_bx2_r <= bx2_nxt;
      s1_by2_r <= by2_nxt;
      s1_aw_r  <= first_span_x;
      s1_ah_r  <= first_span_y;
      s1_bw_r  <= second_span_x;
      s1_bh_r  <= second_span_y;
    end
  end

  // stage 2: strict overlap test and intersection width and height
  ctl_t          s2_ctl_r;
  logic [CB-1:0] s2_iw_r, s2_ih_r;
  logic [CB-1:0] s2_aw_r, s2_ah_r, s2_bw_r, s2_bh_r;

  logic                 touch_nxt;
  logic signed [EW-1:0] ix, iy, fx, fy, dx, dy;
  logic [CB-1:0]        iw_nxt, ih_nxt;

  assign touch_nxt = (s1_ax2_r > s1_bx_r) && (s1_bx2_r > s1_ax_r) &&
                     (s1_ay2_r > s1_by_r) && (s1_by2_r > s1_ay_r);
  assign ix = (s1_ax_r > s1_bx_r) ? s1_ax_r : s1_bx_r;
  assign iy = (s1_ay_r > s1_by_r) ? s1_ay_r : s1_by_r;
  assign fx = (s1_ax2_r < s1_bx2_r) ? s1_ax2_r : s1_bx2_r;
  assign fy = (s1_ay2_r < s1_by2_r) ? s1_ay2_r : s1_by2_r;
  assign dx = fx - ix;
  assign dy = fy - iy;
  // an overlap is never wider than the narrower span, so the low bits suffice
  assign iw_nxt = touch_nxt ? dx[CB-1:0] : '0;
  assign ih_nxt = touch_nxt ? dy[CB-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (advance) begin
      s2_ctl_r.valid <= s1_valid_r;
      s2_ctl_r.touch <= touch_nxt;
      s2_ctl_r.keep  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_iw_r <= iw_nxt;
      s2_ih_r <= ih_nxt;
      s2_aw_r <= s1_aw_r;
      s2_ah_r <= s1_ah_r;
      s2_bw_r <= s1_bw_r;
      s2_bh_r <= s1_bh_r;
    end
  end

  // stage 3: intersection and box areas
  ctl_t          s3_ctl_r;
  logic [AW-1:0] s3_ai_r, s3_aa_r, s3_ab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (advance) begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_ai_r <= s2_iw_r * s2_ih_r;
      s3_aa_r <= s2_aw_r * s2_ah_r;
      s3_ab_r <= s2_bw_r * s2_bh_r;
    end
  end

  // stage 4: union area
  ctl_t        s4_ctl_r;
  logic [AW-1:0] s4_ai_r;
  logic [AW:0]   s4_au_r;
  logic [AW:0]   au_nxt;

  assign au_nxt = {1'b0, s3_aa_r} + {1'b0, s3_ab_r} - {1'b0, s3_ai_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (advance) begin
      s4_ctl_r.valid <= s3_ctl_r.valid;
      s4_ctl_r.touch <= s3_ctl_r.touch;
      s4_ctl_r.keep  <= s3_ctl_r.touch && (|au_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_ai_r <= s3_ai_r;
      s4_au_r <= au_nxt;
    end
  end

  assign ctl_out    = s4_ctl_r;
  assign area_i_out = s4_ai_r;
  assign area_u_out = s4_au_r;

endmodule : boi_geom

`default_nettype wire

>>> sv/boi_div_cell.sv
// ----------------------------------------------------------------------------
// boi_div_cell
// One restoring division step: compare, subtract, hand the doubled remainder
// and the grown quotient to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module boi_div_cell #(
  parameter int REM_BITS = 34,
  parameter int QUO_BITS = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire boi_pkg::ctl_t         ctl_in,
  input  wire logic [REM_BITS-1:0]   rem_in,
  input  wire logic [REM_BITS-2:0]   div_in,
  input  wire logic [QUO_BITS-1:0]   quo_in,
  output boi_pkg::ctl_t              ctl_out,
  output logic [REM_BITS-1:0]        rem_out,
  output logic [REM_BITS-2:0]        div_out,
  output logic [QUO_BITS-1:0]        quo_out
);
  import boi_pkg::*;

  ctl_t                ctl_r;
  logic [REM_BITS-1:0] rem_r;
  logic [REM_BITS-2:0] div_r;
  logic [QUO_BITS-1:0] quo_r;

  logic                ge;
  logic [REM_BITS-1:0] diff;
  logic [REM_BITS-1:0] kept;

  // trial subtract; the remainder stays below the divisor, so doubling fits
  assign diff = rem_in - {1'b0, div_in};
  assign ge   = rem_in >= {1'b0, div_in};
  assign kept = ge ? diff : rem_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (advance) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_r <= {kept[REM_BITS-2:0], 1'b0};
      div_r <= div_in;
      quo_r <= {quo_in[QUO_BITS-2:0], ge};
    end
  end

  assign ctl_out = ctl_r;
  assign rem_out = rem_r;
  assign div_out = div_r;
  assign quo_out = quo_r;

endmodule : boi_div_cell

`default_nettype wire

>>> sv/boi_divider.sv
// ----------------------------------------------------------------------------
// boi_divider
// Chain of division cells, one quotient bit per cell, giving
// floor(area_i * 2^RATIO_BITS / area_u).
// ----------------------------------------------------------------------------
`default_nettype none

module boi_divider #(
  parameter int COORD_BITS = boi_pkg::COORD_BITS_DEF,
  parameter int RATIO_BITS = boi_pkg::RATIO_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire boi_pkg::ctl_t         ctl_in,
  input  wire logic [2*COORD_BITS-1:0] area_i,
  input  wire logic [2*COORD_BITS:0] area_u,
  output boi_pkg::ctl_t              ctl_out,
  output logic [RATIO_BITS:0]        quo_out
);
  import boi_pkg::*;

  localparam int AW = 2 * COORD_BITS;
  localparam int RW = AW + 2;
  localparam int QW = RATIO_BITS + 1;

  ctl_t          ctl_w [QW+1];
  logic [RW-1:0] rem_w [QW+1];
  logic [RW-2:0] div_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];

  // head of the chain: remainder starts as the intersection area
  assign ctl_w[0] = ctl_in;
  assign rem_w[0] = {2'b00, area_i};
  assign div_w[0] = area_u;
  assign quo_w[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    boi_div_cell #(
      .REM_BITS (RW),
      .QUO_BITS (QW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .ctl_in  (ctl_w[k]),
      .rem_in  (rem_w[k]),
      .div_in  (div_w[k]),
      .quo_in  (quo_w[k]),
      .ctl_out (ctl_w[k+1]),
      .rem_out (rem_w[k+1]),
      .div_out (div_w[k+1]),
      .quo_out (quo_w[k+1])
    );
  end

  // the last remainder and divisor are not needed past the chain
  assign ctl_out = ctl_w[QW];
  assign quo_out = quo_w[QW];

endmodule : boi_divider

`default_nettype wire

>>> sv/box_intersection_over_union.sv
// ----------------------------------------------------------------------------
// box_intersection_over_union
// Streaming intersection over union of two axis-aligned boxes.
// ----------------------------------------------------------------------------
// Takes one box pair per clock and returns one result per pair, in order. A
// result passes through four front-end stages (far edges, overlap test,
// areas, union), one division cell per quotient bit (RATIO_BITS + 1 cells),
// and the output register. Throughput is one pair per cycle whenever the
// result side takes data; a stall on out_tready holds the whole pipeline,
// and in_tready follows it. The ratio is floor(intersection * 2^RATIO_BITS /
// union), so 2^RATIO_BITS means 1.0; pairs that do not strictly overlap on
// both axes give a ratio of zero with boxes_touch low.
// ----------------------------------------------------------------------------
`default_nettype none

module box_intersection_over_union #(
  parameter int COORD_BITS = boi_pkg::COORD_BITS_DEF,
  parameter int RATIO_BITS = boi_pkg::RATIO_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // box pair input
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // first_left, first_top, first_span_x, first_span_y,
  // second_left, second_top, second_span_x, second_span_y
  input  wire logic [8*COORD_BITS-1:0] in_tdata,
  // result output
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // overlap_ratio, zero filled to whole bytes
  output logic [((RATIO_BITS+8)/8)*8-1:0] out_tdata,
  // boxes_touch
  output logic                         out_tuser
);
  import boi_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int AW    = 2 * COORD_BITS;
  localparam int QW    = RATIO_BITS + 1;
  localparam int OUT_W = ((RATIO_BITS + 8) / 8) * 8;

  // whole pipeline moves when the output register is free or being drained
  logic advance;
  logic out_valid_r;
  logic [QW-1:0] ratio_r;
  logic touch_r;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  // front end
  ctl_t          geom_ctl;
  logic [AW-1:0] area_i;
  logic [AW:0]   area_u;

  boi_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .in_valid      (in_tvalid),
    .first_left    (in_tdata[0*CB +: CB]),
    .first_top     (in_tdata[1*CB +: CB]),
    .first_span_x  (in_tdata[2*CB +: CB]),
    .first_span_y  (in_tdata[3*CB +: CB]),
    .second_left   (in_tdata[4*CB +: CB]),
    .second_top    (in_tdata[5*CB +: CB]),
    .second_span_x (in_tdata[6*CB +: CB]),
    .second_span_y (in_tdata[7*CB +: CB]),
    .ctl_out       (geom_ctl),
    .area_i_out    (area_i),
    .area_u_out    (area_u)
  );

  // quotient chain
  ctl_t          div_ctl;
  logic [QW-1:0] quo;

  boi_divider #(
    .COORD_BITS (COORD_BITS),
    .RATIO_BITS (RATIO_BITS)
  ) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ctl_in  (geom_ctl),
    .area_i  (area_i),
    .area_u  (area_u),
    .ctl_out (div_ctl),
    .quo_out (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= div_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ratio_r <= div_ctl.keep ? quo : '0;
      touch_r <= div_ctl.touch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(ratio_r);
  assign out_tuser  = touch_r;

endmodule : box_intersection_over_union

`default_nettype wire
